>>> sv/cvc_pkg.sv
package cvc_pkg;

    typedef struct packed {
        logic [1:0]         cmd;
        logic               shape_kind;
        logic signed [31:0] pos_x;
        logic signed [31:0] pos_y;
        logic signed [31:0] pos_z;
        logic signed [31:0] extent_x;
        logic signed [31:0] extent_y;
        logic signed [31:0] extent_z;
        logic signed [31:0] speed_x;
        logic signed [31:0] speed_y;
        logic signed [31:0] speed_z;
    } t_in_item;

    typedef struct packed {
        logic               status;
        logic [4:0]         hit_id;
        logic signed [31:0] hit_vel_x;
        logic signed [31:0] hit_vel_y;
        logic signed [31:0] hit_vel_z;
    } t_out_item;

    typedef enum logic [1:0] {
        CMD_CLEAR = 2'd0,
        CMD_LOAD  = 2'd1,
        CMD_QUERY = 2'd2,
        CMD_NONE  = 2'd3
    } t_cmd;

    typedef enum logic [3:0] {
        ST_IDLE,
        ST_CENTER,
        ST_READ,
        ST_AXIS,
        ST_DIV,
        ST_SQR,
        ST_ACC,
        ST_DONE,
        ST_OUT
    } t_state;

    localparam logic [31:0] SAT_POS = 32'h7FFF_FFFF;
    localparam logic [31:0] ONE_Q16 = 32'h0001_0000;
    localparam logic [31:0] PITCH_RST = 32'h0001_0000;
    localparam logic        REG_PITCH = 1'b0;

    // Divider handshake
    typedef struct packed {
        logic        start;
        logic [47:0] num;
        logic [31:0] den;
    } t_div_req;

    typedef struct packed {
        logic        done;
        logic [47:0] quo;
    } t_div_rsp;

endpackage

>>> sv/cvc_divider.sv
module cvc_divider (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  cvc_pkg::t_div_req i_req,
    output cvc_pkg::t_div_rsp o_rsp
);
    import cvc_pkg::*;

    // Restoring divider, one quotient bit per cycle.
    logic [47:0] r_quo, n_quo;
    logic [32:0] r_rem, n_rem;
    logic [31:0] r_den, n_den;
    logic [5:0]  r_cnt, n_cnt;
    logic        r_busy, n_busy;
    logic        r_done, n_done;
    logic [32:0] w_sh;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
            r_cnt  <= '0;
        end else begin
            r_busy <= n_busy;
            r_done <= n_done;
            r_cnt  <= n_cnt;
        end
        r_quo <= n_quo;
        r_rem <= n_rem;
        r_den <= n_den;
    end

    always_comb begin
        n_quo  = r_quo;
        n_rem  = r_rem;
        n_den  = r_den;
        n_cnt  = r_cnt;
        n_busy = r_busy;
        n_done = 1'b0;
        w_sh   = {r_rem[31:0], r_quo[47]};
        if (i_req.start) begin
            n_quo  = i_req.num;
            n_rem  = '0;
            n_den  = i_req.den;
            n_cnt  = 6'd48;
            n_busy = 1'b1;
        end else if (r_busy) begin
            if (w_sh >= {1'b0, r_den}) begin
                n_rem = w_sh - {1'b0, r_den};
                n_quo = {r_quo[46:0], 1'b1};
            end else begin
                n_rem = w_sh;
                n_quo = {r_quo[46:0], 1'b0};
            end
            n_cnt = r_cnt - 6'd1;
            if (r_cnt == 6'd1) begin
                n_busy = 1'b0;
                n_done = 1'b1;
            end
        end
    end

    assign o_rsp.done = r_done;
    assign o_rsp.quo  = r_quo;
endmodule

>>> sv/collider_voxel_classifier.sv
// Channel | Direction | Handshake            | Payload
// in      | input     | i_in_valid/o_in_ready | cvc_pkg::t_in_item
// out     | output    | o_out_valid/i_out_ready | cvc_pkg::t_out_item
// cfg     | input     | APB psel/penable     | grid pitch register at addresses 0-3
//
// Clear and load: the result is registered the cycle after the item is taken.
// A query does, per stored ellipsoid, one table read, then per axis: start,
// divide in the shared 48-step restoring divider, square, accumulate; a zero
// radius ends the ellipsoid as a miss. A box needs no divider. One item at a
// time: o_in_ready is high only when idle and the result register is empty, so
// the next item is taken only after the result is taken and the state is back
// in idle. Reset is synchronous, active low; it clears the count and control.
// A stalled result holds in the output register until taken.
module collider_voxel_classifier #(
    parameter int MAX_COLLIDERS = 16
) (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_in_valid,
    output logic               o_in_ready,
    input  cvc_pkg::t_in_item  i_in_data,
    output logic               o_out_valid,
    input  logic               i_out_ready,
    output cvc_pkg::t_out_item o_out_data,
    input  logic               psel,
    input  logic               penable,
    input  logic               pwrite,
    input  logic [2:0]         paddr,
    input  logic [31:0]        pwdata,
    output logic [31:0]        prdata,
    output logic               pready
);
    import cvc_pkg::*;

    localparam int IW = (MAX_COLLIDERS > 1) ? $clog2(MAX_COLLIDERS) : 1;
    localparam int CW = $clog2(MAX_COLLIDERS + 1);

    // Shape table
    logic               m_kind [MAX_COLLIDERS];
    logic signed [31:0] m_cx   [MAX_COLLIDERS];
    logic signed [31:0] m_cy   [MAX_COLLIDERS];
    logic signed [31:0] m_cz   [MAX_COLLIDERS];
    logic signed [31:0] m_ex   [MAX_COLLIDERS];
    logic signed [31:0] m_ey   [MAX_COLLIDERS];
    logic signed [31:0] m_ez   [MAX_COLLIDERS];
    logic [31:0]        m_vx   [MAX_COLLIDERS];
    logic [31:0]        m_vy   [MAX_COLLIDERS];
    logic [31:0]        m_vz   [MAX_COLLIDERS];

    t_state r_state, n_state;
    logic [30:0] r_cell;
    logic [CW-1:0] r_count, n_count;
    logic [CW-1:0] r_k, n_k;
    logic [CW-1:0] r_win, n_win;
    logic [1:0] r_axis, n_axis;
    logic [1:0] r_pc, n_pc;
    t_in_item r_item;
    logic signed [31:0] r_p [3];
    logic signed [31:0] n_p;
    logic        r_okind;
    logic signed [31:0] r_oc [3];
    logic signed [31:0] r_oe [3];
    logic        r_hold, n_hold;
    logic [31:0] r_sum, n_sum;
    logic [31:0] r_q, n_q;
    logic [63:0] r_sq;
    logic        r_ovalid, n_ovalid;
    t_out_item   r_out, n_out;
    logic        w_load;
    logic [IW-1:0] w_ridx, w_widx;
    t_div_req    w_dreq;
    t_div_rsp    w_drsp;

    // Per-axis working values
    logic signed [31:0] w_idx;
    logic signed [65:0] w_prod;
    logic signed [65:0] w_half;
    logic signed [32:0] w_d;
    logic [32:0] w_mag;
    logic [31:0] w_rmag;
    logic signed [31:0] w_c, w_e;
    logic [33:0] w_acc;

    assign pready = 1'b1;
    assign prdata = {1'b0, r_cell};
    assign o_in_ready = (r_state == ST_IDLE) && !r_ovalid;
    assign o_out_valid = r_ovalid;
    assign o_out_data = r_out;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cell <= PITCH_RST[30:0];
        end else if (psel && penable && pwrite && paddr[2] == REG_PITCH) begin
            r_cell <= pwdata[30:0];
        end
    end

    cvc_divider u_div (
        .i_clk  (i_clk),
        .i_rst_n(i_rst_n),
        .i_req  (w_dreq),
        .o_rsp  (w_drsp)
    );

    assign w_widx = r_count[IW-1:0];
    assign w_ridx = r_k[IW-1:0];
    assign w_load = (r_state == ST_DONE) && (r_item.cmd == CMD_LOAD)
                    && (r_count < CW'(MAX_COLLIDERS));

    always_ff @(posedge i_clk) begin
        if (w_load) begin
            m_kind[w_widx] <= r_item.shape_kind;
            m_cx[w_widx] <= r_item.pos_x;
            m_cy[w_widx] <= r_item.pos_y;
            m_cz[w_widx] <= r_item.pos_z;
            m_ex[w_widx] <= r_item.extent_x;
            m_ey[w_widx] <= r_item.extent_y;
            m_ez[w_widx] <= r_item.extent_z;
            m_vx[w_widx] <= r_item.speed_x;
            m_vy[w_widx] <= r_item.speed_y;
            m_vz[w_widx] <= r_item.speed_z;
        end
        if (r_state == ST_READ) begin
            r_okind <= m_kind[w_ridx];
            r_oc[0] <= m_cx[w_ridx];
            r_oc[1] <= m_cy[w_ridx];
            r_oc[2] <= m_cz[w_ridx];
            r_oe[0] <= m_ex[w_ridx];
            r_oe[1] <= m_ey[w_ridx];
            r_oe[2] <= m_ez[w_ridx];
        end
    end

    // Cell center of one axis: floor((2i+1)*cs/2), saturated
    always_comb begin
        case (r_pc)
            2'd0:    w_idx = r_item.pos_x;
            2'd1:    w_idx = r_item.pos_y;
            default: w_idx = r_item.pos_z;
        endcase
        w_prod = 66'(signed'({w_idx, 1'b1})) * signed'({35'd0, r_cell});
        w_half = w_prod >>> 1;
        if (w_half > 66'sh7FFF_FFFF)
            n_p = 32'sh7FFF_FFFF;
        else if (w_half < -66'sh8000_0000)
            n_p = 32'sh8000_0000;
        else
            n_p = w_half[31:0];
    end

    always_comb begin
        w_c = r_oc[r_axis];
        w_e = r_oe[r_axis];
        w_d = 33'(r_p[r_axis]) - 33'(w_c);
        w_mag = w_d[32] ? 33'(-w_d) : 33'(w_d);
        w_rmag = w_e[31] ? 32'(-w_e) : 32'(w_e);
        w_acc = 34'(r_sum) + (r_sq[63:16] > 48'(SAT_POS) ? 34'(SAT_POS)
                                                          : 34'(r_sq[47:16]));
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state  <= ST_IDLE;
            r_count  <= '0;
            r_ovalid <= 1'b0;
        end else begin
            r_state  <= n_state;
            r_count  <= n_count;
            r_ovalid <= n_ovalid;
        end
        if (o_in_ready && i_in_valid) r_item <= i_in_data;
        if (r_state == ST_CENTER) r_p[r_pc] <= n_p;
        r_k    <= n_k;
        r_win  <= n_win;
        r_axis <= n_axis;
        r_pc   <= n_pc;
        r_hold <= n_hold;
        r_sum  <= n_sum;
        r_q    <= n_q;
        r_sq   <= 64'(r_q) * 64'(r_q);
        r_out  <= n_out;
    end

    always_comb begin
        n_state  = r_state;
        n_count  = r_count;
        n_k      = r_k;
        n_win    = r_win;
        n_axis   = r_axis;
        n_pc     = r_pc;
        n_hold   = r_hold;
        n_sum    = r_sum;
        n_q      = r_q;
        n_ovalid = r_ovalid;
        n_out    = r_out;
        w_dreq.start = 1'b0;
        w_dreq.num   = {w_mag[31:0], 16'd0};
        w_dreq.den   = w_rmag;
        if (r_ovalid && i_out_ready) n_ovalid = 1'b0;
        unique case (r_state)
            ST_IDLE: begin
                n_k = '0;
                n_win = '0;
                n_pc = '0;
                if (i_in_valid && o_in_ready) begin
                    n_state = (i_in_data.cmd == CMD_QUERY) ? ST_CENTER : ST_DONE;
                end
            end
            ST_CENTER: begin
                n_pc = r_pc + 2'd1;
                if (r_pc == 2'd2) n_state = ST_READ;
            end
            ST_READ: begin
                n_axis = '0;
                n_hold = 1'b1;
                n_sum  = '0;
                n_state = (r_k < r_count) ? ST_AXIS : ST_DONE;
            end
            ST_AXIS: begin
                if (r_okind) begin
                    if ($signed({1'b0, w_mag}) > 34'(w_e)) n_hold = 1'b0;
                    n_axis = r_axis + 2'd1;
                    if (r_axis == 2'd2) n_state = ST_ACC;
                end else if (w_e == 32'sd0) begin
                    n_hold = 1'b0;
                    n_state = ST_ACC;
                end else begin
                    // |d| < 2^32 fits 48-bit numerator exactly
                    w_dreq.num = {w_mag[31:0], 16'd0};
                    if (w_mag[32]) w_dreq.num = 48'hFFFF_FFFF_FFFF;
                    w_dreq.start = 1'b1;
                    n_state = ST_DIV;
                end
            end
            ST_DIV: begin
                if (w_drsp.done) begin
                    n_q = (w_drsp.quo > 48'(SAT_POS)) ? SAT_POS : w_drsp.quo[31:0];
                    n_state = ST_SQR;
                end
            end
            ST_SQR: begin
                n_state = ST_ACC;
            end
            ST_ACC: begin
                if (!r_okind && r_hold) begin
                    n_sum = (w_acc > 34'(SAT_POS)) ? SAT_POS : w_acc[31:0];
                    if (r_axis != 2'd2) begin
                        n_axis = r_axis + 2'd1;
                        n_state = ST_AXIS;
                    end else begin
                        if (n_sum <= ONE_Q16) n_win = r_k + CW'(1);
                        n_k = r_k + CW'(1);
                        n_state = ST_READ;
                    end
                end else begin
                    if (r_hold) n_win = r_k + CW'(1);
                    n_k = r_k + CW'(1);
                    n_state = ST_READ;
                end
            end
            ST_DONE: begin
                n_out = '0;
                unique case (r_item.cmd)
                    CMD_CLEAR: n_count = '0;
                    CMD_LOAD: begin
                        if (r_count < CW'(MAX_COLLIDERS)) n_count = r_count + CW'(1);
                        else n_out.status = 1'b1;
                    end
                    CMD_QUERY: begin
                        n_out.hit_id = 5'(r_win);
                        if (r_win != '0) begin
                            n_out.hit_vel_x = m_vx[IW'(r_win - CW'(1))];
                            n_out.hit_vel_y = m_vy[IW'(r_win - CW'(1))];
                            n_out.hit_vel_z = m_vz[IW'(r_win - CW'(1))];
                        end
                    end
                    default: ;
                endcase
                n_ovalid = 1'b1;
                n_state  = ST_OUT;
            end
            ST_OUT: begin
                n_state = ST_IDLE;
            end
            default: n_state = ST_IDLE;
        endcase
    end
endmodule

>>> sv/cvc_checker.sv
module cvc_checker (
    input logic               i_clk,
    input logic               i_rst_n,
    input logic               i_in_valid,
    input logic               o_in_ready,
    input logic               o_out_valid,
    input logic               i_out_ready,
    input cvc_pkg::t_out_item o_out_data
);
    import cvc_pkg::*;

    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && !i_out_ready |=> o_out_valid && $stable(o_out_data))
        else $error("result changed while stalled");

    a_no_accept_pending: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid |-> !o_in_ready)
        else $error("input taken with result pending");

    a_busy_after_accept: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_in_valid && o_in_ready |=> !o_in_ready)
        else $error("ready right after accept");

    a_status_clean: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && o_out_data.status |-> o_out_data.hit_id == 5'd0)
        else $error("refused load with hit");
endmodule

bind collider_voxel_classifier cvc_checker u_cvc_checker (
    .i_clk      (i_clk),
    .i_rst_n    (i_rst_n),
    .i_in_valid (i_in_valid),
    .o_in_ready (o_in_ready),
    .o_out_valid(o_out_valid),
    .i_out_ready(i_out_ready),
    .o_out_data (o_out_data)
);
